@@ sv/tte_pkg.sv @@
// Package for the token expiry table: sizes, opcodes, register indexes,
// the entry and write-back structures and the controller state type.
// Used by tte_cell, tte_ctrl and ttl_token_expiry_table; depends on nothing.
package tte_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths.
    localparam int OP_W    = 2;
    localparam int KEY_W   = 32;
    localparam int TIME_W  = 32;
    localparam int EXP_W   = 33;
    localparam int TTL_W   = 27;
    localparam int COUNT_W = 7;

    // Count saturates at the largest value of the result field.
    localparam int COUNT_MAX = 127;

    // Configuration port.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_TTL = 1'b0;
    localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(5);

    // Opcodes. The unused code behaves as a count.
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_GEN   = 2'd0;
    localparam t_op OP_RENEW = 2'd1;
    localparam t_op OP_COUNT = 2'd2;

    // One table entry as it travels round the ring.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [EXP_W-1:0] expiry;
    } t_entry;

    // Write-back from the controller to one cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_wr;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    // Clamp an exact live count to the width of the result field.
    function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        if (32'(c) > 32'(COUNT_MAX)) begin
            return COUNT_W'(COUNT_MAX);
        end
        return COUNT_W'(c);
    endfunction

endpackage

@@ sv/tte_cell.sv @@
// One cell of the entry ring: holds a single table entry.
// Depends on tte_pkg for the entry structure.
module tte_cell
    import tte_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_next,
    input  logic   i_wr_en,
    input  t_entry i_wr_entry,
    output t_entry o_entry
);

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [EXP_W-1:0] r_expiry;

    // The valid bit is control state and clears at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_next.valid;
        end else if (i_wr_en) begin
            r_valid <= i_wr_entry.valid;
        end
    end

    // Key and expiry are only meaningful once the valid bit is set.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_key    <= i_next.key;
            r_expiry <= i_next.expiry;
        end else if (i_wr_en) begin
            r_key    <= i_wr_entry.key;
            r_expiry <= i_wr_entry.expiry;
        end
    end

    assign o_entry = '{valid: r_valid, key: r_key, expiry: r_expiry};

endmodule

@@ sv/tte_ctrl.sv @@
// Request controller: captures an item, scans the ring one entry per cycle,
// then writes back the chosen entry and presents the result item.
// Depends on tte_pkg.
module tte_ctrl
    import tte_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [TTL_W-1:0]    i_ttl,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [KEY_W-1:0]    i_token_key,
    input  logic [TIME_W-1:0]   i_current_time,
    input  t_entry              i_head,
    output logic                o_shift,
    output t_wr                 o_wr,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [COUNT_W-1:0]  o_unexpired_count,
    output logic                o_accepted
);

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(ENTRIES - 1);

    t_state r_state;
    t_state n_state;

    logic [IDX_W-1:0]   r_step;
    t_op                r_op;
    logic [KEY_W-1:0]   r_key;
    logic [TIME_W-1:0]  r_now;
    logic [EXP_W-1:0]   r_expiry;

    logic               r_match_found;
    logic [IDX_W-1:0]   r_match_idx;
    logic               r_match_live;
    logic               r_free_found;
    logic [IDX_W-1:0]   r_free_idx;
    logic [CNT_W-1:0]   r_count;

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_acc;

    logic               w_accept;
    logic               w_out_free;
    logic               w_commit;
    logic               w_head_live;
    logic               w_head_match;
    logic               w_gen_ok;
    logic               w_renew_ok;
    logic               w_do_wr;
    logic               w_acc;
    logic               w_old_live;
    logic               w_new_live;
    logic [CNT_W-1:0]   w_count_fin;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_commit   = (r_state == S_COMMIT) && w_out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready = 1'b0;
        o_shift    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_SCAN: begin
                o_shift = 1'b1;
            end
            S_COMMIT: begin
                o_in_ready = 1'b0;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request; the expiry is formed once, here.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_opcode;
            r_key    <= i_token_key;
            r_now    <= i_current_time;
            r_expiry <= {1'b0, i_current_time} + EXP_W'(i_ttl);
        end
    end

    // Comparisons on the entry that currently sits at the head of the ring.
    assign w_head_live  = i_head.valid && (i_head.expiry > {1'b0, r_now});
    assign w_head_match = i_head.valid && (i_head.key == r_key);

    // Scan accumulators: first key match, first free or expired slot, live count.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_step        <= '0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_count       <= '0;
        end else if (r_state == S_SCAN) begin
            r_step <= r_step + IDX_W'(1);
            if (w_head_match && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_idx   <= r_step;
                r_match_live  <= w_head_live;
            end
            if (!w_head_live && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_step;
            end
            if (w_head_live) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    // Decision once the scan is complete.
    assign w_gen_ok   = r_match_found || r_free_found;
    assign w_renew_ok = r_match_found && r_match_live;
    assign w_old_live = r_match_found && r_match_live;
    assign w_new_live = r_expiry > {1'b0, r_now};

    always_comb begin
        case (r_op)
            OP_GEN: begin
                w_do_wr = w_gen_ok;
                w_acc   = w_gen_ok;
            end
            OP_RENEW: begin
                w_do_wr = w_renew_ok;
                w_acc   = w_renew_ok;
            end
            default: begin
                w_do_wr = 1'b0;
                w_acc   = 1'b1;
            end
        endcase
    end

    // The written entry replaces its old liveness with its new one.
    always_comb begin
        w_count_fin = r_count;
        if (w_do_wr) begin
            w_count_fin = r_count - CNT_W'(w_old_live) + CNT_W'(w_new_live);
        end
    end

    assign o_wr.en           = w_commit && w_do_wr;
    assign o_wr.idx          = r_match_found ? r_match_idx : r_free_idx;
    assign o_wr.entry.valid  = 1'b1;
    assign o_wr.entry.key    = r_key;
    assign o_wr.entry.expiry = r_expiry;

    // Output register: holds the result item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_count <= sat_count(w_count_fin);
            r_out_acc   <= w_acc;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_unexpired_count = r_out_count;
    assign o_accepted        = r_out_acc;

    // A write-back happens only when the result can be loaded.
    a_wr_in_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> (r_state == S_COMMIT) && w_out_free)
        else $error("entry written outside commit");

    // The scan ends after exactly one pass round the ring.
    a_scan_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (r_step == LAST_STEP) |=> (r_state == S_COMMIT))
        else $error("scan did not end after the last entry");

    // Leaving commit always presents a result item.
    a_commit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> o_out_valid && (r_state == S_IDLE))
        else $error("commit did not present a result");

    // The live count never exceeds the number of entries visited.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> (32'(r_count) <= ENTRIES))
        else $error("live count out of range");

endmodule

@@ sv/ttl_token_expiry_table.sv @@
// Top level of the token expiry table: configuration register, ring of
// entry cells and the request controller.
// Depends on tte_pkg, tte_cell and tte_ctrl.
//
// Usage:
//   Requests arrive on the input channel (i_in_valid / o_in_ready) as an
//   opcode, a 32-bit key and the current time. Each item yields exactly one
//   result item on the output channel (o_out_valid / i_out_ready): the number
//   of entries still live after the update, and an accepted flag.
//   The 64 entries sit in a ring of cells. A request rotates the ring once,
//   one entry per cycle past the controller, which finds the matching key,
//   the first free or expired slot and the live count; the commit state then
//   writes the chosen entry back and loads the result register.
//   A new item is accepted only while the controller is idle, so a request is
//   not taken before the previous one has been committed.
//   The result register holds its item while the receiver stalls; the next
//   item may be accepted meanwhile, and its write-back waits for the register.
//   Reset (synchronous, active low) empties the table and sets the
//   time-to-live register to 5. The register sits at byte address 0; the user
//   must write it only while the block is idle, which the block does not enforce.
module ttl_token_expiry_table
    import tte_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OP_W-1:0]     i_opcode,
    input  logic [KEY_W-1:0]    i_token_key,
    input  logic [TIME_W-1:0]   i_current_time,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [COUNT_W-1:0]  o_unexpired_count,
    output logic                o_accepted
);

    logic [TTL_W-1:0] r_ttl;
    logic             w_reg_sel;
    logic             w_shift;
    t_wr              w_wr;
    t_entry           w_ring [ENTRIES];

    // Configuration register.
    assign w_reg_sel = (paddr[ADDR_W-1] == REG_TTL);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= TTL_RESET;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_ttl <= pwdata[TTL_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? DATA_W'(r_ttl) : '0;

    // Ring of cells: each takes its neighbour's entry while the ring rotates.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tte_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_shift    (w_shift),
            .i_next     (w_ring[(g + 1) % ENTRIES]),
            .i_wr_en    (w_wr.en && (w_wr.idx == IDX_W'(g))),
            .i_wr_entry (w_wr.entry),
            .o_entry    (w_ring[g])
        );
    end

    // Controller sees the entry at the head of the ring.
    tte_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ttl             (r_ttl),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_token_key       (i_token_key),
        .i_current_time    (i_current_time),
        .i_head            (w_ring[0]),
        .o_shift           (w_shift),
        .o_wr              (w_wr),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_unexpired_count (o_unexpired_count),
        .o_accepted        (o_accepted)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the token expiry table: drives requests and the
// time-to-live register, predicts every result and checks each one in order.
// Depends on tte_pkg and the ttl_token_expiry_table top level.
module testbench;
    import tte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Run control.
    localparam int LATENCY     = ENTRIES + 2;
    localparam int HOLD_CYCLES = 600;
    localparam int IDLE_LIMIT  = 4 * (HOLD_CYCLES + LATENCY + 16);
    localparam logic [ADDR_W-1:0] TTL_ADDR = ADDR_W'(4 * REG_TTL);
    localparam logic [TTL_W-1:0]  TTL_MAX  = TTL_W'(100000000);
    // The fourth opcode is decoded as a count.
    localparam t_op OP_SPARE = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] live_count;
        logic               accepted;
    } t_reply;

    // Clock, reset and block inputs, all known from time zero.
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [ADDR_W-1:0]  paddr          = '0;
    logic [DATA_W-1:0]  pwdata         = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [OP_W-1:0]    i_opcode       = '0;
    logic [KEY_W-1:0]   i_token_key    = '0;
    logic [TIME_W-1:0]  i_current_time = '0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [COUNT_W-1:0] o_unexpired_count;
    logic               o_accepted;

    // Shadow copy of the table and of the register.
    logic               shadow_live   [ENTRIES];
    logic [KEY_W-1:0]   shadow_key    [ENTRIES];
    logic [EXP_W-1:0]   shadow_expiry [ENTRIES];
    logic [TTL_W-1:0]   shadow_ttl = TTL_RESET;

    t_reply pending_replies [$];
    t_reply want;

    int error_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int refused_count  = 0;
    int ttl_writes     = 0;
    int idle_cycles    = 0;
    int stall_request  = 0;
    int result_gap;
    int hold_left;

    ttl_token_expiry_table u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_token_key       (i_token_key),
        .i_current_time    (i_current_time),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_unexpired_count (o_unexpired_count),
        .o_accepted        (o_accepted)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Applies one request to the shadow table and returns the result it yields.
    function automatic t_reply apply_request(input t_op op, input logic [KEY_W-1:0] key,
                                             input logic [TIME_W-1:0] now);
        t_reply           r;
        logic [EXP_W-1:0] new_expiry;
        logic [EXP_W-1:0] now_x;
        int               slot;
        int               n;
        now_x      = EXP_W'(now);
        new_expiry = now_x + EXP_W'(shadow_ttl);
        r.accepted = 1'b1;
        slot       = -1;
        if (op == OP_GEN) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && shadow_live[i] && shadow_key[i] == key) slot = i;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && (!shadow_live[i] || shadow_expiry[i] <= now_x)) slot = i;
            end
            if (slot >= 0) begin
                shadow_live[slot]   = 1'b1;
                shadow_key[slot]    = key;
                shadow_expiry[slot] = new_expiry;
            end else begin
                r.accepted = 1'b0;
            end
        end else if (op == OP_RENEW) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (slot < 0 && shadow_live[i] && shadow_key[i] == key) slot = i;
            end
            // Only a live entry may be refreshed.
            if (slot >= 0 && shadow_expiry[slot] > now_x) begin
                shadow_expiry[slot] = new_expiry;
            end else begin
                r.accepted = 1'b0;
            end
        end
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (shadow_live[i] && shadow_expiry[i] > now_x && n < COUNT_MAX) n++;
        end
        r.live_count = COUNT_W'(n);
        return r;
    endfunction

    // Offers one request after a random gap and records its expected result.
    task automatic send_request(input t_op op, input logic [KEY_W-1:0] key,
                                input logic [TIME_W-1:0] now);
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid     <= 1'b0;
            i_opcode       <= OP_W'($urandom);
            i_token_key    <= $urandom;
            i_current_time <= $urandom;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_token_key    <= key;
        i_current_time <= now;
        do @(posedge i_clk); while (!o_in_ready);
        pending_replies = {pending_replies, apply_request(op, key, now)};
        items_sent++;
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
    endtask

    // Writes the time-to-live register and reads it back.
    task automatic write_ttl(input logic [TTL_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TTL_ADDR;
        pwdata  <= DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_ttl = value;
        ttl_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(value)) begin
            $error("time_to_live readback: expected %0d, got %0d", value, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hand-picked requests: empty table, field extremes, every opcode, expired
    // renew, zero time-to-live, expiry beyond 32 bits and time running backwards.
    task automatic test_directed_cases();
        send_request(OP_COUNT, 32'h0000_0000, 32'd0);
        send_request(OP_RENEW, 32'h0000_0000, 32'd0);
        send_request(OP_GEN,   32'h0000_0000, 32'd0);
        send_request(OP_GEN,   32'hFFFF_FFFF, 32'd1);
        send_request(OP_RENEW, 32'h0000_0000, 32'd4);
        send_request(OP_SPARE, 32'h1234_5678, 32'd6);
        send_request(OP_RENEW, 32'hFFFF_FFFF, 32'd6);
        send_request(OP_GEN,   32'h0000_0001, 32'd6);
        send_request(OP_GEN,   32'h0000_0000, 32'd7);
        send_request(OP_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain_results();
        write_ttl('0);
        send_request(OP_GEN,   32'hA5A5_A5A5, 32'd100);
        send_request(OP_RENEW, 32'hA5A5_A5A5, 32'd100);
        send_request(OP_COUNT, 32'h0000_0000, 32'd99);
        drain_results();
        write_ttl(TTL_MAX);
        send_request(OP_GEN,   32'h5A5A_5A5A, 32'hFFFF_FFFF);
        send_request(OP_RENEW, 32'h5A5A_5A5A, 32'hFFFF_FFFF);
        send_request(OP_COUNT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_COUNT, 32'h0000_0000, 32'd0);
        drain_results();
        write_ttl(TTL_W'(1));
        send_request(OP_GEN,   32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_COUNT, 32'h0000_0000, 32'h7FFF_FFFF);
        send_request(OP_COUNT, 32'h0000_0000, 32'h8000_0000);
        drain_results();
    endtask

    // Fills every slot with long-lived keys so that further generates are
    // refused, then lets the whole table expire and reuses a slot.
    task automatic test_table_full();
        logic [KEY_W-1:0]  stored [$];
        logic [TIME_W-1:0] now;
        logic [KEY_W-1:0]  key;
        write_ttl(TTL_MAX);
        now = $urandom_range(0, 32'hF000_0000);
        for (int i = 0; i < ENTRIES + 6; i++) begin
            key = $urandom;
            stored = {stored, key};
            send_request(OP_GEN, key, now);
        end
        send_request(OP_RENEW, stored[0], now + 32'd1);
        send_request(OP_RENEW, stored[ENTRIES - 1], now + 32'd2);
        send_request(OP_RENEW, stored[ENTRIES + 2], now + 32'd2);
        send_request(OP_GEN, stored[5], now + 32'd3);
        send_request(OP_COUNT, $urandom, now + 32'd3);
        send_request(OP_COUNT, $urandom, now + TIME_W'(TTL_MAX) + 32'd3);
        send_request(OP_GEN, $urandom, now + TIME_W'(TTL_MAX) + 32'd3);
        drain_results();
    endtask

    // Holds the result channel off for a long stretch while requests keep
    // coming, so the block fills and stalls its input.
    task automatic test_backpressure();
        logic [TIME_W-1:0] now;
        write_ttl(TTL_W'($urandom_range(10, 1000)));
        now = $urandom;
        stall_request = HOLD_CYCLES;
        for (int i = 0; i < 12; i++) begin
            now = now + TIME_W'($urandom_range(0, 50));
            send_request(t_op'($urandom_range(0, 3)), KEY_W'($urandom_range(0, 5)), now);
        end
        drain_results();
    endtask

    // Random traffic over a small key pool with time mostly moving forward.
    task automatic test_random_traffic(input int n_items, input logic [TTL_W-1:0] ttl,
                                       input logic [TIME_W-1:0] start, input int step_max,
                                       input int pool_size);
        logic [KEY_W-1:0]  pool [$];
        logic [TIME_W-1:0] now;
        logic [KEY_W-1:0]  key;
        t_op               op;
        int                pick;
        for (int i = 0; i < pool_size; i++) pool = {pool, KEY_W'($urandom)};
        pool[0] = '0;
        pool[pool_size - 1] = '1;
        write_ttl(ttl);
        now = start;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      op = OP_GEN;
            else if (pick < 75) op = OP_RENEW;
            else if (pick < 95) op = OP_COUNT;
            else                op = OP_SPARE;
            if ($urandom_range(0, 9) == 0) key = $urandom;
            else                           key = pool[$urandom_range(0, pool_size - 1)];
            // Occasionally time steps back; the block must not care.
            if ($urandom_range(0, 99) < 3) begin
                now = now - TIME_W'($urandom_range(0, 4 * step_max));
            end else begin
                now = now + TIME_W'($urandom_range(0, step_max));
            end
            send_request(op, key, now);
            if ($urandom_range(0, 79) == 0) drain_results();
        end
        drain_results();
    endtask

    // Result receiver: random stall per item, or a long hold when asked.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_request > 0) begin
                hold_left = stall_request;
                stall_request = 0;
                i_out_ready <= 1'b0;
                repeat (hold_left) @(negedge i_clk);
            end else begin
                result_gap = $urandom_range(0, 3);
                if (result_gap > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (result_gap) @(negedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // Result checker: every accepted item against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_replies.size() == 0) begin
                $error("result item with no request waiting: unexpired_count %0d, accepted %0d",
                       o_unexpired_count, o_accepted);
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (!want.accepted) refused_count++;
                if (o_unexpired_count !== want.live_count) begin
                    $error("unexpired_count: expected %0d, got %0d",
                           want.live_count, o_unexpired_count);
                    error_count++;
                end
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, o_accepted);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ttl_token_expiry_table verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_live[i]   = 1'b0;
            shadow_key[i]    = '0;
            shadow_expiry[i] = '0;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_table_full();
        test_backpressure();
        test_random_traffic(150, TTL_RESET, $urandom, 3, 12);
        test_random_traffic(120, TTL_W'(1), $urandom, 2, 8);
        test_random_traffic(200, TTL_MAX, 32'hF000_0000 + $urandom_range(0, 32'h0700_0000),
                            1 << 20, 90);
        test_random_traffic(240, TTL_W'($urandom_range(1, 1000)), $urandom, 200, 40);
        test_random_traffic(60, '0, $urandom, 4, 8);
        test_random_traffic(160, TTL_W'($urandom_range(1, 100000000)), $urandom, 1 << 24, 48);

        drain_results();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            $error("%0d expected results never arrived", pending_replies.size());
            error_count++;
        end

        $display("Covered %0d requests and %0d results, %0d of them refused,",
                 items_sent, results_seen, refused_count);
        $display("over %0d time-to-live settings including zero and the maximum.", ttl_writes);
        if (error_count == 0) begin
            $display("ttl_token_expiry_table verification clean");
        end else begin
            $display("ttl_token_expiry_table verification failed");
        end
        $finish;
    end

endmodule
